[sv/snd_pkg.sv]
// ----------------------------------------------------------------------------
// snd_pkg
// shared types and codes for the shared neighbor density block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package snd_pkg;

    // command kinds
    typedef enum logic [1:0] {
        KIND_SLOT   = 2'd0,
        KIND_LABEL  = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_NEIGHBOURS = 1'b1;

    localparam int ROW_W   = 10;
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 32;
    localparam int REACH_W = 11;
    localparam int DENS_W  = 5;
    localparam int CFG_W   = 5;

    // one queued transaction
    typedef struct packed {
        kind_t                      kind;
        logic [ROW_W-1:0]           row;
        logic [SLOT_W-1:0]          slot;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

endpackage

[sv/snd_front.sv]
// ----------------------------------------------------------------------------
// snd_front
// accepts transactions, drops unused kinds and queues the rest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snd_front
    import snd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                kind,
    input  logic [ROW_W-1:0]          row,
    input  logic [SLOT_W-1:0]         slot,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      busy,
    output logic                      cmd_valid,
    output cmd_t                      cmd,
    input  logic                      cmd_pop
);

    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    // classification: unused kinds are taken but never queued
    assign busy      = (count_reg == 2'd2);
    assign push      = start && !busy && (kind != KIND_UNUSED);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{kind: kind_t'(kind), row: row, slot: slot, value: value};
        end
    end

endmodule

[sv/snd_back.sv]
// ----------------------------------------------------------------------------
// snd_back
// table storage and the query sequencer (gather, sort, merge count)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snd_back
    import snd_pkg::*;
#(
    parameter int ROWS = 1024,
    parameter int MAXN = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  cmd_t                      cmd,
    output logic                      cmd_pop,
    input  logic [CFG_W-1:0]          thr,
    input  logic [$clog2(MAXN+1)-1:0] k_use,
    output logic                      strobe,
    output logic signed [VALUE_W-1:0] flow_label,
    output logic [REACH_W-1:0]        reachable,
    output logic                      has_reachable,
    output logic [DENS_W-1:0]         density,
    output logic                      last
);

    localparam int RW    = $clog2(ROWS);
    localparam int NBW   = $clog2(ROWS + 1);
    localparam int SW    = (MAXN > 1) ? $clog2(MAXN) : 1;
    localparam int KW    = $clog2(MAXN + 1);
    localparam int DEPTH = ROWS * MAXN;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_GATHER = 6'b000010,
        S_SETUP  = 6'b000100,
        S_MERGE  = 6'b001000,
        S_EVAL   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // table memories
    logic [NBW-1:0]            nbr_mem [DEPTH];
    logic signed [VALUE_W-1:0] lbl_mem [ROWS];
    logic [NBW-1:0]            nbr_rd_reg;
    logic signed [VALUE_W-1:0] lbl_rd_reg;
    logic                      nbr_we, lbl_we;
    logic [AW-1:0]             nbr_waddr, nbr_raddr;
    logic [NBW-1:0]            nbr_wdata;
    logic [RW-1:0]             cmd_row_idx;

    // sequencer state
    logic [RW-1:0]  row_reg, row_next;
    logic           row_ok_reg, row_ok_next;
    logic [RW-1:0]  g_row_reg, g_row_next;
    logic [NBW-1:0] own_reg [MAXN];
    logic [NBW-1:0] own_next [MAXN];
    logic [NBW-1:0] other_reg [MAXN];
    logic [NBW-1:0] other_next [MAXN];
    logic [KW-1:0]  n_own_reg, n_own_next;
    logic [KW-1:0]  n_other_reg, n_other_next;
    logic [KW-1:0]  s_reg, s_next;
    logic           rd_pend_reg, rd_pend_next;
    logic           into_own_reg, into_own_next;
    logic [KW-1:0]  i_reg, i_next;
    logic [NBW-1:0] nb_reg, nb_next;
    logic [KW-1:0]  p_reg, p_next;
    logic [KW-1:0]  q_reg, q_next;
    logic [KW-1:0]  c_reg, c_next;
    logic           pend_vld_reg, pend_vld_next;
    logic [NBW-1:0] pend_nb_reg, pend_nb_next;
    logic [KW-1:0]  dens_reg, dens_next;

    // result registers
    logic                      strobe_reg, strobe_next;
    logic signed [VALUE_W-1:0] label_out_reg, label_out_next;
    logic [REACH_W-1:0]        reach_out_reg, reach_out_next;
    logic                      has_out_reg, has_out_next;
    logic [DENS_W-1:0]         dens_out_reg, dens_out_next;
    logic                      last_out_reg, last_out_next;

    // helpers
    logic [31:0]    row_wide, slot_wide, nb_wide, dens_wide;
    logic           cmd_row_ok, cmd_slot_ok, cmd_val_ok;
    logic [SW-1:0]  own_addr;
    logic [NBW-1:0] own_rd, other_rd;
    logic [NBW-1:0] nb_minus;
    logic [NBW-1:0] ins_src [MAXN];
    logic [NBW-1:0] ins_list [MAXN];
    logic [MAXN-1:0] ins_le;
    logic [KW-1:0]  ins_cnt;
    logic [KW-1:0]  i_plus;

    // command decode
    assign row_wide    = 32'(cmd.row);
    assign slot_wide   = 32'(cmd.slot);
    assign cmd_row_ok  = row_wide < 32'(ROWS);
    assign cmd_slot_ok = slot_wide < 32'(MAXN);
    assign cmd_val_ok  = !cmd.value[31] && (cmd.value != '0)
                         && ($unsigned(cmd.value) <= 32'(ROWS));
    assign cmd_row_idx = row_wide[RW-1:0];
    assign nbr_waddr   = AW'(cmd_row_idx) * AW'(MAXN) + AW'(cmd.slot);
    assign nbr_wdata   = cmd_val_ok ? cmd.value[NBW-1:0] : '0;
    assign nbr_raddr   = AW'(g_row_reg) * AW'(MAXN) + AW'(s_reg[SW-1:0]);

    // list reads
    assign own_addr = (state_reg == S_MERGE) ? p_reg[SW-1:0] : i_reg[SW-1:0];
    assign own_rd   = own_reg[own_addr];
    assign other_rd = other_reg[q_reg[SW-1:0]];
    assign nb_minus = own_rd - NBW'(1);
    assign i_plus   = i_reg + KW'(1);

    // sorted insert of the fetched entry into the list being gathered
    always_comb
    begin
        ins_cnt = into_own_reg ? n_own_reg : n_other_reg;
        for (int j = 0; j < MAXN; j++)
        begin
            ins_src[j] = into_own_reg ? own_reg[j] : other_reg[j];
        end
        for (int j = 0; j < MAXN; j++)
        begin
            ins_le[j] = (32'(j) < 32'(ins_cnt)) && (ins_src[j] <= nbr_rd_reg);
        end
        for (int j = 0; j < MAXN; j++)
        begin
            if (ins_le[j])
            begin
                ins_list[j] = ins_src[j];
            end
            else if (j == 0)
            begin
                ins_list[j] = nbr_rd_reg;
            end
            else if (ins_le[(j > 0) ? j - 1 : 0])
            begin
                ins_list[j] = nbr_rd_reg;
            end
            else
            begin
                ins_list[j] = ins_src[(j > 0) ? j - 1 : 0];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        row_ok_next    = row_ok_reg;
        g_row_next     = g_row_reg;
        own_next       = own_reg;
        other_next     = other_reg;
        n_own_next     = n_own_reg;
        n_other_next   = n_other_reg;
        s_next         = s_reg;
        rd_pend_next   = 1'b0;
        into_own_next  = into_own_reg;
        i_next         = i_reg;
        nb_next        = nb_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        c_next         = c_reg;
        pend_vld_next  = pend_vld_reg;
        pend_nb_next   = pend_nb_reg;
        dens_next      = dens_reg;
        strobe_next    = 1'b0;
        label_out_next = label_out_reg;
        reach_out_next = reach_out_reg;
        has_out_next   = has_out_reg;
        dens_out_next  = dens_out_reg;
        last_out_next  = last_out_reg;
        cmd_pop        = 1'b0;
        nbr_we         = 1'b0;
        lbl_we         = 1'b0;
        nb_wide        = 32'(pend_nb_reg);
        dens_wide      = 32'(dens_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        KIND_SLOT:
                        begin
                            nbr_we = cmd_row_ok && cmd_slot_ok;
                        end
                        KIND_LABEL:
                        begin
                            lbl_we = cmd_row_ok;
                        end
                        KIND_QUERY:
                        begin
                            row_next      = cmd_row_idx;
                            row_ok_next   = cmd_row_ok;
                            g_row_next    = cmd_row_idx;
                            into_own_next = 1'b1;
                            n_own_next    = '0;
                            s_next        = '0;
                            pend_vld_next = 1'b0;
                            dens_next     = '0;
                            state_next    = cmd_row_ok ? S_GATHER : S_FINISH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_GATHER:
            begin
                // issue one slot read per cycle
                if (s_reg < k_use)
                begin
                    s_next       = s_reg + KW'(1);
                    rd_pend_next = 1'b1;
                end
                // take in the returned entry
                if (rd_pend_reg && (nbr_rd_reg != '0))
                begin
                    if (into_own_reg)
                    begin
                        own_next   = ins_list;
                        n_own_next = n_own_reg + KW'(1);
                    end
                    else
                    begin
                        other_next   = ins_list;
                        n_other_next = n_other_reg + KW'(1);
                    end
                end
                if ((s_reg == k_use) && !rd_pend_reg)
                begin
                    if (into_own_reg)
                    begin
                        i_next     = '0;
                        state_next = (n_own_reg == '0) ? S_FINISH : S_SETUP;
                    end
                    else
                    begin
                        p_next     = '0;
                        q_next     = '0;
                        c_next     = '0;
                        state_next = S_MERGE;
                    end
                end
            end
            S_SETUP:
            begin
                nb_next       = own_rd;
                g_row_next    = nb_minus[RW-1:0];
                n_other_next  = '0;
                s_next        = '0;
                into_own_next = 1'b0;
                state_next    = S_GATHER;
            end
            S_MERGE:
            begin
                // one step of the sorted intersection walk
                if ((p_reg < n_own_reg) && (q_reg < n_other_reg))
                begin
                    if (own_rd < other_rd)
                    begin
                        p_next = p_reg + KW'(1);
                    end
                    else if (other_rd < own_rd)
                    begin
                        q_next = q_reg + KW'(1);
                    end
                    else
                    begin
                        c_next = c_reg + KW'(1);
                        p_next = p_reg + KW'(1);
                        q_next = q_reg + KW'(1);
                    end
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // hold one reachable result back until the next is known
                if (32'(c_reg) >= 32'(thr))
                begin
                    if (pend_vld_reg)
                    begin
                        strobe_next    = 1'b1;
                        label_out_next = lbl_rd_reg;
                        reach_out_next = nb_wide[REACH_W-1:0];
                        has_out_next   = 1'b1;
                        dens_out_next  = '0;
                        last_out_next  = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_nb_next  = nb_reg;
                    dens_next     = dens_reg + KW'(1);
                end
                i_next     = i_plus;
                state_next = (i_plus < n_own_reg) ? S_SETUP : S_FINISH;
            end
            S_FINISH:
            begin
                strobe_next    = 1'b1;
                label_out_next = row_ok_reg ? lbl_rd_reg : '0;
                last_out_next  = 1'b1;
                if (pend_vld_reg)
                begin
                    reach_out_next = nb_wide[REACH_W-1:0];
                    has_out_next   = 1'b1;
                    dens_out_next  = dens_wide[DENS_W-1:0];
                end
                else
                begin
                    reach_out_next = '0;
                    has_out_next   = 1'b0;
                    dens_out_next  = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            strobe_reg  <= strobe_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        row_ok_reg    <= row_ok_next;
        g_row_reg     <= g_row_next;
        own_reg       <= own_next;
        other_reg     <= other_next;
        n_own_reg     <= n_own_next;
        n_other_reg   <= n_other_next;
        s_reg         <= s_next;
        into_own_reg  <= into_own_next;
        i_reg         <= i_next;
        nb_reg        <= nb_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        c_reg         <= c_next;
        pend_vld_reg  <= pend_vld_next;
        pend_nb_reg   <= pend_nb_next;
        dens_reg      <= dens_next;
        label_out_reg <= label_out_next;
        reach_out_reg <= reach_out_next;
        has_out_reg   <= has_out_next;
        dens_out_reg  <= dens_out_next;
        last_out_reg  <= last_out_next;
    end

    // neighbor memory
    always_ff @(posedge clk)
    begin
        if (nbr_we)
        begin
            nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        nbr_rd_reg <= nbr_mem[nbr_raddr];
    end

    // label memory
    always_ff @(posedge clk)
    begin
        if (lbl_we)
        begin
            lbl_mem[cmd_row_idx] <= cmd.value;
        end
        lbl_rd_reg <= lbl_mem[row_reg];
    end

    assign strobe        = strobe_reg;
    assign flow_label    = label_out_reg;
    assign reachable     = reach_out_reg;
    assign has_reachable = has_out_reg;
    assign density       = dens_out_reg;
    assign last          = last_out_reg;

endmodule

[sv/shared_neighbor_density.sv]
// ----------------------------------------------------------------------------
// shared_neighbor_density
// shared nearest neighbor density over a table of flows
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. Kind 0 writes
//   one neighbor slot, kind 1 writes a row label, kind 2 queries a row; kind
//   3 is taken and dropped. A two-entry queue sits between intake and the
//   sequencer, so busy rises only when two commands are waiting.
//   Loads are written from the sequencer's idle state. In a query, every
//   slot is one read of the single neighbor memory port, and the
//   shared-entry count walks both sorted lists one step a cycle.
//   Results come out one per strobe cycle, in ascending neighbor order; the
//   last one carries the density. Results cannot be stalled.
//   Registers are written through write_enable / write_index / write_data.
//   Reset clears control and sets threshold 1, slots in use 16. Table
//   contents are undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shared_neighbor_density
    import snd_pkg::*;
#(
    parameter int ROWS           = 1024,
    parameter int MAX_NEIGHBOURS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                kind,
    input  logic [ROW_W-1:0]          row,
    input  logic [SLOT_W-1:0]         slot,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      write_enable,
    input  logic                      write_index,
    input  logic [CFG_W-1:0]          write_data,
    output logic                      strobe,
    output logic signed [VALUE_W-1:0] flow_label,
    output logic [REACH_W-1:0]        reachable,
    output logic                      has_reachable,
    output logic [DENS_W-1:0]         density,
    output logic                      last
);

    localparam int KW = $clog2(MAX_NEIGHBOURS + 1);

    logic [CFG_W-1:0] thr_reg, thr_next;
    logic [CFG_W-1:0] nin_reg, nin_next;
    logic [KW-1:0]    k_use;
    logic             cmd_valid, cmd_pop;
    cmd_t             cmd;

    // configuration registers
    always_comb
    begin
        thr_next = thr_reg;
        nin_next = nin_reg;
        if (write_enable)
        begin
            case (write_index)
                REG_THRESHOLD:  thr_next = write_data;
                REG_NEIGHBOURS: nin_next = write_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= CFG_W'(1);
            nin_reg <= CFG_W'(16);
        end
        else
        begin
            thr_reg <= thr_next;
            nin_reg <= nin_next;
        end
    end

    // slots in use saturate at the row width
    assign k_use = (32'(nin_reg) > 32'(MAX_NEIGHBOURS)) ? KW'(MAX_NEIGHBOURS) : KW'(nin_reg);

    snd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .row       (row),
        .slot      (slot),
        .value     (value),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    snd_back #(
        .ROWS (ROWS),
        .MAXN (MAX_NEIGHBOURS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .thr           (thr_reg),
        .k_use         (k_use),
        .strobe        (strobe),
        .flow_label    (flow_label),
        .reachable     (reachable),
        .has_reachable (has_reachable),
        .density       (density),
        .last          (last)
    );

endmodule

[sv/snd_checker.sv]
// ----------------------------------------------------------------------------
// snd_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snd_checker
    import snd_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      strobe,
    input logic [REACH_W-1:0]        reachable,
    input logic                      has_reachable,
    input logic [DENS_W-1:0]         density,
    input logic                      last
);

    // a result without a neighbor always closes the query
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !has_reachable |-> last)
        else $error("empty result not marked last");

    // density shows only on the closing result
    a_density_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> density == '0)
        else $error("density on a non-final result");

    // empty result names no row
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !has_reachable |-> reachable == '0 && density == '0)
        else $error("empty result carries data");

    // a non-final result is never directly followed by an empty one, so density follows
    a_final_density: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> !strobe || has_reachable)
        else $error("reachable list ended without a neighbor on its last result");

endmodule

bind shared_neighbor_density snd_checker u_snd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .strobe        (strobe),
    .reachable     (reachable),
    .has_reachable (has_reachable),
    .density       (density),
    .last          (last)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the shared neighbor density block: a table of
// rows is loaded with known contents, then directed and random loads, queries
// and dropped commands run under several register settings while a scoreboard
// predicts every result and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import snd_pkg::*;

    localparam int NROWS    = 1024;
    localparam int NSLOTS   = 16;
    localparam int NKNOWN   = 8;
    localparam int SETTLE   = 1100;
    localparam int WD_LIMIT = 20000;
    localparam int PHASE_N  = 12;

    // one expected result
    typedef struct {
        logic signed [VALUE_W-1:0] label;
        logic [REACH_W-1:0]        reach;
        logic                      has;
        logic [DENS_W-1:0]         dens;
        logic                      fin;
    } snd_result_t;

    // density predictor and store of expected results
    class density_scoreboard;
        int                        nbr [NROWS][NSLOTS];
        logic signed [VALUE_W-1:0] labels [NROWS];
        int                        threshold;
        int                        slots_used;
        snd_result_t               expected_q [$];
        int                        errors;

        function new();
            threshold  = 1;
            slots_used = 16;
            errors     = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == REG_THRESHOLD)
                threshold = int'(data);
            else
                slots_used = int'(data);
        endfunction

        // append one expectation at the tail
        function void queue_result(snd_result_t res);
            expected_q.insert(expected_q.size(), res);
        endfunction

        // non-empty neighbors of a row, ascending, duplicates kept
        function int gather(int r, output int lst [NSLOTS]);
            int k;
            int cnt;
            int key;
            int b;
            k   = (slots_used > NSLOTS) ? NSLOTS : slots_used;
            cnt = 0;
            for (int s = 0; s < k; s++)
                if (nbr[r][s] != 0)
                begin
                    lst[cnt] = nbr[r][s];
                    cnt++;
                end
            for (int a = 1; a < cnt; a++)
            begin
                key = lst[a];
                b   = a;
                while (b > 0 && lst[b-1] > key)
                begin
                    lst[b] = lst[b-1];
                    b--;
                end
                lst[b] = key;
            end
            return cnt;
        endfunction

        // accepted transaction: update the table or queue the query results
        function void note_cmd(kind_t kd, int r, int s, logic signed [VALUE_W-1:0] v);
            int          own [NSLOTS];
            int          other [NSLOTS];
            int          n_own;
            int          n_other;
            int          p;
            int          q;
            int          c;
            int          dens;
            snd_result_t res;
            case (kd)
                KIND_SLOT:
                    nbr[r][s] = (v <= 0 || v > NROWS) ? 0 : int'(v);
                KIND_LABEL:
                    labels[r] = v;
                KIND_QUERY:
                begin
                    dens  = 0;
                    n_own = gather(r, own);
                    for (int i = 0; i < n_own; i++)
                    begin
                        n_other = gather(own[i] - 1, other);
                        p = 0;
                        q = 0;
                        c = 0;
                        while (p < n_own && q < n_other)
                        begin
                            if (own[p] < other[q])
                                p++;
                            else if (other[q] < own[p])
                                q++;
                            else
                            begin
                                c++;
                                p++;
                                q++;
                            end
                        end
                        if (c >= threshold)
                        begin
                            res.label = labels[r];
                            res.reach = REACH_W'(own[i]);
                            res.has   = 1'b1;
                            res.dens  = '0;
                            res.fin   = 1'b0;
                            queue_result(res);
                            dens++;
                        end
                    end
                    if (dens == 0)
                    begin
                        res.label = labels[r];
                        res.reach = '0;
                        res.has   = 1'b0;
                        res.dens  = '0;
                        res.fin   = 1'b1;
                        queue_result(res);
                    end
                    else
                    begin
                        expected_q[$].dens = DENS_W'(dens);
                        expected_q[$].fin  = 1'b1;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        // compare one result with the oldest expectation
        function void check_result(snd_result_t act);
            snd_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result label %0d reach %0d", $time,
                         act.label, act.reach);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (act.label !== exp_r.label)
            begin
                $display("%0t: flow_label exp %0d act %0d", $time, exp_r.label, act.label);
                errors++;
            end
            if (act.reach !== exp_r.reach)
            begin
                $display("%0t: reachable exp %0d act %0d", $time, exp_r.reach, act.reach);
                errors++;
            end
            if (act.has !== exp_r.has)
            begin
                $display("%0t: has_reachable exp %0b act %0b", $time, exp_r.has, act.has);
                errors++;
            end
            if (act.dens !== exp_r.dens)
            begin
                $display("%0t: density exp %0d act %0d", $time, exp_r.dens, act.dens);
                errors++;
            end
            if (act.fin !== exp_r.fin)
            begin
                $display("%0t: last exp %0b act %0b", $time, exp_r.fin, act.fin);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    kind_t                     kind;
    logic [ROW_W-1:0]          row;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
    logic                      write_enable;
    logic                      write_index;
    logic [CFG_W-1:0]          write_data;
    logic                      strobe;
    logic signed [VALUE_W-1:0] flow_label;
    logic [REACH_W-1:0]        reachable;
    logic                      has_reachable;
    logic [DENS_W-1:0]         density;
    logic                      last;

    density_scoreboard sb;
    int                idle_cycles;
    bit                no_gaps;

    shared_neighbor_density uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .row           (row),
        .slot          (slot),
        .value         (value),
        .write_enable  (write_enable),
        .write_index   (write_index),
        .write_data    (write_data),
        .strobe        (strobe),
        .flow_label    (flow_label),
        .reachable     (reachable),
        .has_reachable (has_reachable),
        .density       (density),
        .last          (last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result capture
    always @(posedge clk)
    begin
        snd_result_t act;
        if (rst_n && strobe)
        begin
            act.label = flow_label;
            act.reach = reachable;
            act.has   = has_reachable;
            act.dens  = density;
            act.fin   = last;
            sb.check_result(act);
        end
    end

    // watchdog on cycles with no accepted transaction and no result
    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // table rows that are fully written and may be referenced
    function automatic int known_row(int i);
        return (i < NKNOWN / 2) ? i : NROWS - NKNOWN + i;
    endfunction

    // mostly a valid neighbor number, sometimes an empty one
    function automatic logic signed [VALUE_W-1:0] rand_neighbor();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom | 32'h8000_0000;
            2: return $urandom_range(1025, 32'h7fff_ffff);
            default: return known_row($urandom_range(0, NKNOWN - 1)) + 1;
        endcase
    endfunction

    // present one transaction and hold it until taken
    task automatic send_cmd(kind_t kd, int r, int s, logic signed [VALUE_W-1:0] v);
        start <= 1'b1;
        kind  <= kd;
        row   <= ROW_W'(r);
        slot  <= SLOT_W'(s);
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_cmd(kd, r, s, v);
    endtask

    // random gap between transactions, mostly short
    task automatic sender_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        g = 0;
        if (!no_gaps)
            g = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(20, 150);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // wait for all results, then let trailing loads finish
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(posedge clk);
        write_enable <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic random_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_cmd(KIND_SLOT, known_row($urandom_range(0, NKNOWN - 1)),
                     $urandom_range(0, 15), rand_neighbor());
        else if (r < 58)
            send_cmd(KIND_LABEL, known_row($urandom_range(0, NKNOWN - 1)), 0, $urandom);
        else if (r < 95)
            send_cmd(KIND_QUERY, known_row($urandom_range(0, NKNOWN - 1)),
                     $urandom_range(0, 15), $urandom);
        else
            send_cmd(KIND_UNUSED, $urandom_range(0, NROWS - 1), $urandom_range(0, 15),
                     $urandom);
        sender_gap();
    endtask

    // main sequence
    initial
    begin
        int thr_set [7] = '{0, 16, 2, 1, 31, 3, 1};
        int k_set   [7] = '{16, 16, 8, 1, 16, 0, 31};
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_SLOT;
        row          = '0;
        slot         = '0;
        value        = '0;
        write_enable = 1'b0;
        write_index  = REG_THRESHOLD;
        write_data   = '0;
        no_gaps      = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every referenced row so nothing unwritten is ever read
        for (int i = 0; i < NKNOWN; i++)
        begin
            send_cmd(KIND_LABEL, known_row(i), 0, $urandom);
            for (int s = 0; s < NSLOTS; s++)
                send_cmd(KIND_SLOT, known_row(i), s, rand_neighbor());
        end

        // directed: label extremes, empty encodings, duplicates, dropped kind
        send_cmd(KIND_LABEL, 0, 0, 32'sh8000_0000);
        send_cmd(KIND_LABEL, 1023, 0, 32'sh7fff_ffff);
        send_cmd(KIND_SLOT, 0, 0, 1024);
        send_cmd(KIND_SLOT, 0, 3, 1024);
        send_cmd(KIND_SLOT, 0, 15, 1025);
        send_cmd(KIND_SLOT, 0, 1, -1);
        send_cmd(KIND_SLOT, 0, 2, 0);
        send_cmd(KIND_SLOT, 0, 4, 32'sh7fff_ffff);
        send_cmd(KIND_SLOT, 1023, 5, 1);
        send_cmd(KIND_SLOT, 1023, 6, 1);
        send_cmd(KIND_UNUSED, 1023, 15, -1);
        send_cmd(KIND_QUERY, 0, 0, 0);
        send_cmd(KIND_QUERY, 1023, 15, -1);
        send_cmd(KIND_SLOT, 1, 7, 1);
        send_cmd(KIND_QUERY, 1, 0, 0);
        drain();

        // random phases under several register settings
        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_THRESHOLD, CFG_W'(thr_set[ph]));
            write_reg(REG_NEIGHBOURS, CFG_W'(k_set[ph]));
            no_gaps = (ph == 2);
            for (int n = 0; n < PHASE_N; n++)
            begin
                random_cmd();
                // occasionally hold off until every result is in
                if ($urandom_range(0, 19) == 0)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (sb.expected_q.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
sv/snd_pkg.sv
sv/snd_front.sv
sv/snd_back.sv
sv/shared_neighbor_density.sv
sv/snd_checker.sv
dv/tb_top.sv
